### hdl/prti_pkg.sv
// ----------------------------------------------------------------------------
// prti_pkg
// Shared types, character codes and arithmetic helpers for the prefixed
// radix text to integer converter.
// ----------------------------------------------------------------------------
package prti_pkg;

   localparam int VALUE_WIDTH = 64;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;

   localparam logic [4:0] RADIX_BIN = 5'd2;
   localparam logic [4:0] RADIX_DEC = 5'd10;
   localparam logic [4:0] RADIX_HEX = 5'd16;

   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SECOND,
      PHASE_SIGN,
      PHASE_DIGITS
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic signed [63:0] parsed_value;
      logic [4:0]         base_used;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] held;
      logic [4:0] radix;
      logic       negate;
      value_type  acc;
   } parse_state_type;

   typedef struct packed {
      logic       emit;
      logic [4:0] radix;
      logic       negate;
      value_type  raw;
   } parse_result_type;

   localparam parse_state_type RESET_STATE = '{
      phase:  PHASE_FIRST,
      held:   8'd0,
      radix:  RADIX_DEC,
      negate: 1'b0,
      acc:    '0
   };

   // The digit is taken without validation and may be negative; it is
   // sign-extended to the value width so the sum wraps at that width.
   function automatic value_type digit_of(input logic [7:0] c);
      logic [7:0]        offset;
      logic signed [8:0] d;
      begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            offset = CHAR_ZERO;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            offset = UPPER_OFFSET;
         end else begin
            offset = LOWER_OFFSET;
         end
         d = $signed({1'b0, c}) - $signed({1'b0, offset});
         return value_type'(d);
      end
   endfunction

   function automatic value_type times_radix(input value_type v, input logic [4:0] radix);
      begin
         case (radix)
            RADIX_HEX: return v << 4;
            RADIX_BIN: return v << 1;
            default:   return (v << 3) + (v << 1);
         endcase
      end
   endfunction

endpackage

### hdl/prti_step.sv
// ----------------------------------------------------------------------------
// prti_step
// Next-state logic for one character: prefix detection, sign capture and
// the shift-and-add accumulate step.
// ----------------------------------------------------------------------------
module prti_step
   import prti_pkg::*;
(
   input  parse_state_type  state,
   input  logic [7:0]       char_code,
   input  logic             is_final,
   output parse_state_type  state_next,
   output parse_result_type result
);

   value_type       digit;
   value_type       held_digit;
   value_type       scaled;
   logic            is_minus;
   logic            held_minus;
   phase_type       phase_next;
   parse_state_type work;

   assign digit      = digit_of(char_code);
   assign held_digit = digit_of(state.held);
   assign scaled     = times_radix(state.acc, state.radix);
   assign is_minus   = (char_code == CHAR_MINUS);
   assign held_minus = (state.held == CHAR_MINUS);

   always_comb begin
      case (state.phase)
         PHASE_FIRST:  phase_next = PHASE_SECOND;
         PHASE_SECOND: begin
            if (char_code == CHAR_X || char_code == CHAR_B) begin
               phase_next = PHASE_SIGN;
            end else begin
               phase_next = PHASE_DIGITS;
            end
         end
         default:      phase_next = PHASE_DIGITS;
      endcase
   end

   always_comb begin
      work       = state;
      work.phase = phase_next;
      case (state.phase)
         PHASE_FIRST: begin
            work.held   = char_code;
            work.radix  = RADIX_DEC;
            work.negate = is_minus;
            work.acc    = is_minus ? '0 : digit;
         end
         PHASE_SECOND: begin
            if (char_code == CHAR_X) begin
               work.radix  = RADIX_HEX;
               work.negate = 1'b0;
               work.acc    = '0;
            end else if (char_code == CHAR_B) begin
               work.radix  = RADIX_BIN;
               work.negate = 1'b0;
               work.acc    = '0;
            end else begin
               work.radix  = RADIX_DEC;
               work.negate = held_minus;
               work.acc    = held_minus ? digit : times_radix(held_digit, RADIX_DEC) + digit;
            end
         end
         PHASE_SIGN: begin
            if (is_minus) begin
               work.negate = 1'b1;
            end else begin
               work.acc = digit;
            end
         end
         default: begin
            work.acc = scaled + digit;
         end
      endcase

      result.emit   = is_final;
      result.radix  = work.radix;
      result.negate = work.negate;
      result.raw    = work.acc;
      state_next    = is_final ? RESET_STATE : work;
   end

endmodule

### hdl/prefixed_radix_text_to_integer.sv
// ----------------------------------------------------------------------------
// prefixed_radix_text_to_integer
// Converts a stream of ASCII characters into a signed integer, with an
// optional 0x or 0b style radix prefix and a leading minus sign.
// ----------------------------------------------------------------------------
// The block takes one character beat per cycle while not stalled and returns
// one result beat for each string, through the input and result registers.
// The rate is set by the accumulate step, a combinational shift-and-add of
// the accumulator by the radix plus the digit. Non-final characters keep
// flowing while a result waits on a stalled output; a final character waits
// only while the result register holds a result that the output stalls.
module prefixed_radix_text_to_integer
   import prti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic             in_valid_ff;
   logic             in_valid_in;
   req_type          in_data_ff;
   logic             advance;
   parse_state_type  state_ff;
   parse_state_type  state_in;
   parse_state_type  state_next;
   parse_result_type result;
   logic             out_valid_ff;
   logic             out_valid_in;
   parse_result_type out_data_ff;
   value_type        signed_value;

   prti_step u_step (
      .state      (state_ff),
      .char_code  (in_data_ff.char_code),
      .is_final   (in_data_ff.is_final),
      .state_next (state_next),
      .result     (result)
   );

   assign advance   = in_valid_ff && (!in_data_ff.is_final || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign state_in     = advance ? state_next : state_ff;
   assign out_valid_in = (advance && result.emit) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= RESET_STATE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_payload;
      end
      if (advance && result.emit) begin
         out_data_ff <= result;
      end
   end

   assign signed_value = out_data_ff.negate ? (value_type'(0) - out_data_ff.raw)
                                             : out_data_ff.raw;

   assign rsp_valid                = out_valid_ff;
   assign rsp_payload.parsed_value = 64'($signed(signed_value));
   assign rsp_payload.base_used    = out_data_ff.radix;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("Input stalled with an empty input register.");

   a_final_fills_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.is_final) |=> out_valid_ff)
      else $error("Final character did not produce a result beat.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("Stalled result beat was lost or changed.");

   a_final_clears_state: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.is_final) |=> (state_ff == RESET_STATE))
      else $error("Parser state not cleared after a final character.");
`endif

endmodule

### tb/sv/tb_prefixed_radix_text_to_integer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefixed_radix_text_to_integer
// Self-checking testbench for the prefixed radix text to integer converter.
// A short table of directed strings is followed by random strings. Most are
// well-formed decimal, 0x or 0b numbers with an optional sign; the rest are
// single characters, bare prefixes and raw byte noise. Directed rows hold
// their results and a behavioral parser predicts the rest; each result beat
// is compared with the oldest expectation. Channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_prefixed_radix_text_to_integer;
   import prti_pkg::*;

   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam int         RANDOM_CHARS    = 2000;
   localparam int         CHUNK_CHARS     = 250;
   localparam int         CALM_TAIL_CHARS = 300;
   localparam int         HOLD_OFF_CYCLES = 300;

   typedef struct {
      logic [7:0] code;
      logic       fin;
      bit         has_lit;
      rsp_type    lit;
   } char_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   phase_type    parse_phase;
   logic [7:0]   held_char;
   logic [4:0]   cur_radix;
   logic         neg_pending;
   value_type    acc_value;
   rsp_type      awaited_values[$];
   char_row_type directed_rows[$];
   int           failures = 0;
   int           chars_sent = 0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;
   bit           pressure_go = 1'b0;

   prefixed_radix_text_to_integer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic value_type char_digit(input logic [7:0] c);
      value_type code;
      code = value_type'(c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return code - value_type'(CHAR_ZERO);
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return code - value_type'(CHAR_UPPER_A) + 64'd10;
      end
      return code - value_type'(CHAR_LOWER_A) + 64'd10;
   endfunction

   function automatic value_type next_acc(input value_type acc, input logic [4:0] radix,
                                          input logic [7:0] c);
      return acc * value_type'(radix) + char_digit(c);
   endfunction

   function automatic logic [7:0] digit_char(input logic [4:0] radix);
      int v;
      v = $urandom_range(0, radix - 1);
      if (v < 10) begin
         return 8'(CHAR_ZERO + v);
      end
      return 8'(($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + v - 10);
   endfunction

   task automatic clear_parse;
      parse_phase = PHASE_FIRST;
      held_char   = 8'd0;
      cur_radix   = RADIX_DEC;
      neg_pending = 1'b0;
      acc_value   = '0;
   endtask

   task automatic convert_char(input logic [7:0] c, input logic fin, input bit has_lit,
                               input rsp_type lit);
      rsp_type predicted;
      case (parse_phase)
         PHASE_FIRST: begin
            held_char = c;
            if (fin) begin
               cur_radix = RADIX_DEC;
               if (c == CHAR_MINUS) neg_pending = 1'b1;
               else acc_value = next_acc(acc_value, cur_radix, c);
            end else begin
               parse_phase = PHASE_SECOND;
            end
         end
         PHASE_SECOND: begin
            if (c == CHAR_X || c == CHAR_B) begin
               cur_radix = (c == CHAR_X) ? RADIX_HEX : RADIX_BIN;
               parse_phase = PHASE_SIGN;
            end else begin
               cur_radix = RADIX_DEC;
               if (held_char == CHAR_MINUS) neg_pending = 1'b1;
               else acc_value = next_acc(acc_value, cur_radix, held_char);
               acc_value = next_acc(acc_value, cur_radix, c);
               parse_phase = PHASE_DIGITS;
            end
         end
         PHASE_SIGN: begin
            if (c == CHAR_MINUS) neg_pending = 1'b1;
            else acc_value = next_acc(acc_value, cur_radix, c);
            parse_phase = PHASE_DIGITS;
         end
         default: begin
            acc_value = next_acc(acc_value, cur_radix, c);
         end
      endcase
      if (fin) begin
         predicted.parsed_value = neg_pending ? -acc_value : acc_value;
         predicted.base_used    = cur_radix;
         awaited_values.push_back(has_lit ? lit : predicted);
         clear_parse();
      end
   endtask

   task automatic add_row(input logic [7:0] c, input logic fin, input bit has_lit,
                          input longint v, input logic [4:0] b);
      char_row_type row;
      row.code               = c;
      row.fin                = fin;
      row.has_lit            = has_lit;
      row.lit.parsed_value   = v;
      row.lit.base_used      = b;
      directed_rows.push_back(row);
   endtask

   // Called at a rising edge; returns at the edge where the beat is accepted.
   task automatic drive_char(input logic [7:0] c, input logic fin, input bit has_lit,
                             input rsp_type lit);
      int gap;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.char_code <= c;
      req_payload.is_final  <= fin;
      do @(posedge clock); while (req_stall);
      convert_char(c, fin, has_lit, lit);
   endtask

   task automatic send_random_string;
      logic [7:0] text[$];
      logic [4:0] radix;
      int         kind;
      int         len;
      bit         noise;
      logic [7:0] first;
      noise = 1'b0;
      radix = RADIX_DEC;
      kind  = $urandom_range(0, 9);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 8);
      first = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CHAR_ZERO;
      case (kind)
         0, 1, 2: begin
            if ($urandom_range(0, 2) == 0) text.push_back(CHAR_MINUS);
         end
         3, 4, 5, 6: begin
            radix = (kind < 5) ? RADIX_HEX : RADIX_BIN;
            text.push_back(first);
            text.push_back((kind < 5) ? CHAR_X : CHAR_B);
            if ($urandom_range(0, 2) == 0) text.push_back(CHAR_MINUS);
         end
         7: begin
            text.push_back(8'($urandom_range(0, 255)));
            len = 0;
         end
         8: begin
            text.push_back(first);
            text.push_back($urandom_range(0, 1) ? CHAR_X : CHAR_B);
            if ($urandom_range(0, 1) == 0) text.push_back(CHAR_MINUS);
            len = 0;
         end
         default: begin
            noise = 1'b1;
         end
      endcase
      repeat (len) begin
         if (noise || $urandom_range(0, 19) == 0) text.push_back(8'($urandom_range(0, 255)));
         else text.push_back(digit_char(radix));
      end
      foreach (text[i]) begin
         drive_char(text[i], i == text.size() - 1, 1'b0, '0);
      end
      chars_sent += text.size();
   endtask

   initial begin : stimulus
      int next_chunk;
      int chunk_index;
      int guard;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      clear_parse();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row("7", 1'b1, 1'b1, 7, RADIX_DEC);
      add_row("-", 1'b1, 1'b1, 0, RADIX_DEC);
      add_row("Z", 1'b1, 1'b1, 35, RADIX_DEC);
      add_row(8'h00, 1'b1, 1'b1, -87, RADIX_DEC);
      add_row(8'hFF, 1'b1, 1'b1, 168, RADIX_DEC);
      add_row("0", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("x", 1'b1, 1'b1, 0, RADIX_HEX);
      add_row("0", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("b", 1'b1, 1'b1, 0, RADIX_BIN);
      add_row("0", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("x", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("f", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("F", 1'b1, 1'b1, 255, RADIX_HEX);
      add_row("-", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("x", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("5", 1'b1, 1'b1, 5, RADIX_HEX);
      add_row("0", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("x", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("-", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("1", 1'b1, 1'b1, -1, RADIX_HEX);
      add_row("-", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("1", 1'b0, 1'b0, 0, RADIX_DEC);
      add_row("2", 1'b1, 1'b1, -12, RADIX_DEC);
      foreach (directed_rows[i]) begin
         drive_char(directed_rows[i].code, directed_rows[i].fin, directed_rows[i].has_lit,
                    directed_rows[i].lit);
      end

      next_chunk  = 0;
      chunk_index = 0;
      while (chars_sent < RANDOM_CHARS) begin
         if (chars_sent >= next_chunk) begin
            next_chunk += CHUNK_CHARS;
            chunk_index++;
            if (chars_sent >= RANDOM_CHARS - CALM_TAIL_CHARS) begin
               req_idle_on = 1'b0;
               rsp_idle_on = 1'b0;
            end else if (chunk_index == 2) begin
               req_idle_on = 1'b0;
               rsp_idle_on = 1'b0;
               pressure_go = 1'b1;
            end else begin
               req_idle_on = ($urandom_range(0, 3) != 0);
               rsp_idle_on = ($urandom_range(0, 3) != 0);
            end
         end
         send_random_string();
      end
      req_valid <= 1'b0;

      guard = 0;
      while (awaited_values.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (awaited_values.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited_values.size());
         failures++;
      end
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : rsp_side
      int span;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (pressure_go) begin
            pressure_go = 1'b0;
            span = HOLD_OFF_CYCLES;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            span = $urandom_range(1, 18);
         end else begin
            span = 0;
         end
         if (span != 0) begin
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_values.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual value %0d base %0d",
                     $time, rsp_payload.parsed_value, rsp_payload.base_used);
            failures++;
         end else begin
            want = awaited_values.pop_front();
            if (rsp_payload.parsed_value !== want.parsed_value) begin
               $display("%0t: parsed_value mismatch, expected %0d, actual %0d",
                        $time, want.parsed_value, rsp_payload.parsed_value);
               failures++;
            end
            if (rsp_payload.base_used !== want.base_used) begin
               $display("%0t: base_used mismatch, expected %0d, actual %0d",
                        $time, want.base_used, rsp_payload.base_used);
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### prefixed_radix_text_to_integer.f
hdl/prti_pkg.sv
hdl/prti_step.sv
hdl/prefixed_radix_text_to_integer.sv
tb/sv/tb_prefixed_radix_text_to_integer.sv
